### src/brcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brcf_pkg: shared definitions for the chunked byte ring buffer
// Sizes, field widths, operation and result codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package brcf_pkg;

  localparam int RING_BYTES = 1024;
  localparam int MAX_CHUNK  = 64;

  localparam int ADDR_W = $clog2(RING_BYTES);
  localparam int CNT_W  = $clog2(RING_BYTES + 1);
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 11;
  localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } brcf_state_t;

  typedef struct packed {
    logic wr_byte;
    logic rd_start;
    logic rd_step;
    logic cfg_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_ok;
    logic rd_final;
  } dp_status_t;

  // Length of a chunk or read: zero counts as one, and it saturates at MAX_CHUNK.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = v;
    if (v == '0) begin
      n = LEN_W'(1);
    end else if (int'(v) > MAX_CHUNK) begin
      n = LEN_W'(MAX_CHUNK);
    end
    return n;
  endfunction

  // Ring size: zero counts as one, and it saturates at RING_BYTES.
  function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = CNT_W'(v);
    if (v == '0) begin
      n = CNT_W'(1);
    end else if (int'(v) > RING_BYTES) begin
      n = CNT_W'(RING_BYTES);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### src/brcf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brcf_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module brcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/brcf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brcf_ctrl: controller for the chunked byte ring buffer
// Accepts words, sequences the byte-per-cycle read bursts and issues
// commands to the datapath.
// ----------------------------------------------------------------------------
module brcf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_operation,
  input  wire logic                cfg_valid,
  input  wire brcf_pkg::dp_status_t status,
  output      logic                busy,
  output      logic                cfg_ready,
  output      brcf_pkg::ctrl_cmd_t cmd
);
  import brcf_pkg::*;

  brcf_state_t state_r;
  brcf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_operation == OP_READ && status.rd_ok) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (status.rd_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    cfg_ready = 1'b1;
    cmd.cfg_write = cfg_valid;
    case (state_r)
      ST_IDLE: begin
        busy         = 1'b0;
        cmd.wr_byte  = start && (in_operation == OP_WRITE);
        cmd.rd_start = start && (in_operation == OP_READ);
      end
      ST_READ: begin
        cmd.rd_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/brcf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brcf_dp: datapath for the chunked byte ring buffer
// Holds the ring offsets, the held count, the chunk tracking, the byte
// store and the result registers.
// ----------------------------------------------------------------------------
module brcf_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire brcf_pkg::ctrl_cmd_t         cmd,
  input  wire logic [brcf_pkg::LEN_W-1:0]  in_chunk_length,
  input  wire logic [brcf_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic [brcf_pkg::CFG_W-1:0]  cfg_data,
  output      brcf_pkg::dp_status_t        status,
  output      logic                        out_valid,
  output      logic                        out_result_kind,
  output      logic                        out_status,
  output      logic [brcf_pkg::BYTE_W-1:0] out_read_byte,
  output      logic                        out_last
);
  import brcf_pkg::*;

  // Advance a ring offset, wrapping at the configured size.
  function automatic logic [ADDR_W-1:0] next_off(input logic [ADDR_W-1:0] off,
                                                 input logic [CNT_W-1:0]  size);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(off) + CNT_W'(1);
    return (inc >= size) ? '0 : inc[ADDR_W-1:0];
  endfunction

  logic [CNT_W-1:0]  ring_size_r, ring_size_nxt;
  logic [ADDR_W-1:0] wr_off_r, wr_off_nxt;
  logic [ADDR_W-1:0] rd_off_r, rd_off_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              adm_r, adm_nxt;
  logic [LEN_W-1:0]  rd_left_r, rd_left_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic              res_kind_r, res_kind_nxt;
  logic              res_status_r, res_status_nxt;
  logic              rd_valid_r, rd_valid_nxt;
  logic              rd_last_r, rd_last_nxt;

  logic [LEN_W-1:0]  len;
  logic [CMP_W-1:0]  len_cmp;
  logic [CMP_W-1:0]  held_cmp;
  logic [CMP_W-1:0]  free_cmp;
  logic [LEN_W-1:0]  left_eff;
  logic [LEN_W-1:0]  left_after;
  logic              adm_eff;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_q;

  assign len      = clamp_len(in_chunk_length);
  assign len_cmp  = CMP_W'(len);
  assign held_cmp = CMP_W'(held_r);
  assign free_cmp = CMP_W'(ring_size_r) - held_cmp;

  assign left_eff   = (left_r == '0) ? len : left_r;
  assign adm_eff    = (left_r == '0) ? (free_cmp >= len_cmp) : adm_r;
  assign left_after = left_eff - LEN_W'(1);

  assign status.rd_ok    = (left_r == '0) && (held_cmp >= len_cmp);
  assign status.rd_final = (rd_left_r == LEN_W'(1));

  assign ram_we = cmd.wr_byte && adm_eff;

  always_comb begin
    ring_size_nxt  = ring_size_r;
    wr_off_nxt     = wr_off_r;
    rd_off_nxt     = rd_off_r;
    held_nxt       = held_r;
    left_nxt       = left_r;
    adm_nxt        = adm_r;
    rd_left_nxt    = rd_left_r;
    res_valid_nxt  = 1'b0;
    res_kind_nxt   = res_kind_r;
    res_status_nxt = res_status_r;
    rd_valid_nxt   = cmd.rd_step;
    rd_last_nxt    = status.rd_final;

    if (cmd.cfg_write) begin
      ring_size_nxt = clamp_size(cfg_data);
      wr_off_nxt    = '0;
      rd_off_nxt    = '0;
      held_nxt      = '0;
      left_nxt      = '0;
      adm_nxt       = 1'b0;
    end else if (cmd.wr_byte) begin
      if (adm_eff) begin
        wr_off_nxt = next_off(wr_off_r, ring_size_r);
        held_nxt   = held_r + CNT_W'(1);
      end
      left_nxt = left_after;
      adm_nxt  = adm_eff;
      if (left_after == '0) begin
        res_valid_nxt  = 1'b1;
        res_kind_nxt   = KIND_WRITE;
        res_status_nxt = adm_eff ? STATUS_OK : STATUS_REFUSED;
        adm_nxt        = 1'b0;
      end
    end else if (cmd.rd_start) begin
      if (status.rd_ok) begin
        rd_left_nxt = len;
        held_nxt    = CNT_W'(held_cmp - len_cmp);
      end else begin
        res_valid_nxt  = 1'b1;
        res_kind_nxt   = KIND_READ;
        res_status_nxt = STATUS_REFUSED;
      end
    end else if (cmd.rd_step) begin
      rd_off_nxt  = next_off(rd_off_r, ring_size_r);
      rd_left_nxt = rd_left_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= CNT_W'(RING_BYTES);
      wr_off_r    <= '0;
      rd_off_r    <= '0;
      held_r      <= '0;
      left_r      <= '0;
      adm_r       <= 1'b0;
      rd_left_r   <= '0;
      res_valid_r <= 1'b0;
      rd_valid_r  <= 1'b0;
    end else begin
      ring_size_r <= ring_size_nxt;
      wr_off_r    <= wr_off_nxt;
      rd_off_r    <= rd_off_nxt;
      held_r      <= held_nxt;
      left_r      <= left_nxt;
      adm_r       <= adm_nxt;
      rd_left_r   <= rd_left_nxt;
      res_valid_r <= res_valid_nxt;
      rd_valid_r  <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_kind_r   <= res_kind_nxt;
    res_status_r <= res_status_nxt;
    rd_last_r    <= rd_last_nxt;
  end

  brcf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_off_r),
    .wdata(in_data_byte),
    .re   (cmd.rd_step),
    .raddr(rd_off_r),
    .rdata(ram_q)
  );

  // Read data comes straight off the RAM output register; otherwise the
  // acknowledgement or refusal register drives the result.
  assign out_valid       = res_valid_r || rd_valid_r;
  assign out_result_kind = rd_valid_r ? KIND_READ : res_kind_r;
  assign out_status      = rd_valid_r ? STATUS_OK : res_status_r;
  assign out_read_byte   = rd_valid_r ? ram_q : '0;
  assign out_last        = rd_valid_r ? rd_last_r : 1'b1;

endmodule
`default_nettype wire

### src/byte_ring_chunk_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_chunk_fifo: byte ring buffer with all-or-nothing chunk transfers
// A write chunk arrives as consecutive byte words and is stored only if it
// fits whole; a read request returns the requested bytes or one refusal.
// ----------------------------------------------------------------------------
// Timing for a user of the block: a word is taken at a rising edge where
// start is high and busy is low. Chunk bytes can be presented back to
// back; the acknowledgement of a chunk appears in the cycle after its
// last byte is taken. A refused read also answers in the cycle after it
// is taken and keeps busy low. An accepted read of n bytes holds busy
// high while the controller walks the single RAM read port one byte per
// cycle; because the RAM read data is registered, the n bytes come out
// back to back once the controller is in its read state and the RAM
// output register has been loaded, the last one marked by out_last, shown
// in the first cycle in which busy is low again. Results are strobed by
// out_valid for exactly one cycle each and cannot be held off, so the
// receiver must take every word as it appears. The ring size register is
// written through cfg_valid (the port is always ready) and empties the
// ring, also abandoning a chunk in progress without acknowledgement; write
// it only while the block is idle.
// There is no clearing pass after reset: the byte store is never read
// before it has been written, because reads are gated by the held count.
// ----------------------------------------------------------------------------
module byte_ring_chunk_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic                        in_operation,
  input  wire logic [brcf_pkg::LEN_W-1:0]  in_chunk_length,
  input  wire logic [brcf_pkg::BYTE_W-1:0] in_data_byte,
  output      logic                        out_valid,
  output      logic                        out_result_kind,
  output      logic                        out_status,
  output      logic [brcf_pkg::BYTE_W-1:0] out_read_byte,
  output      logic                        out_last,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [brcf_pkg::CFG_W-1:0]  cfg_data
);
  import brcf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller decides what happens each cycle; the datapath owns all
  // ring state and produces the result words.
  brcf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_operation(in_operation),
    .cfg_valid   (cfg_valid),
    .status      (status),
    .busy        (busy),
    .cfg_ready   (cfg_ready),
    .cmd         (cmd)
  );

  brcf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_chunk_length(in_chunk_length),
    .in_data_byte   (in_data_byte),
    .cfg_data       (cfg_data),
    .status         (status),
    .out_valid      (out_valid),
    .out_result_kind(out_result_kind),
    .out_status     (out_status),
    .out_read_byte  (out_read_byte),
    .out_last       (out_last)
  );

  // A read burst never has a gap: a byte that is not the last is followed
  // by another read byte in the next cycle.
  a_burst_continuous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_READ && out_status == STATUS_OK && !out_last
    |=> out_valid && out_result_kind == KIND_READ && out_status == STATUS_OK)
    else $error("read burst broken before its last byte");

  // By the time the last byte of a burst is shown, the controller is free.
  a_idle_at_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_READ && out_status == STATUS_OK && out_last
    |-> !busy)
    else $error("controller still busy at the end of a read burst");

  // A refusal is always a single word with no data.
  a_refusal_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_REFUSED |-> out_last && out_read_byte == '0)
    else $error("refusal carries data or is not marked last");

  // Bytes of a burst only follow a cycle in which busy was high.
  a_burst_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_READ && out_status == STATUS_OK
    |-> $past(busy))
    else $error("read byte produced without a read in progress");

endmodule
`default_nettype wire
